// ===== rtl/core/six_axis_hid_report_decoder_macros.svh =====
// Assertion helpers for the report decoder. Both sample on the rising edge of clk
// and are switched off while arst_n is low.
`ifndef SIX_AXIS_HID_REPORT_DECODER_MACROS_SVH
`define SIX_AXIS_HID_REPORT_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHDR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHDR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/shdr_pkg.sv =====
package shdr_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_TRANSLATION = 2'd0;
	localparam logic [1:0] KIND_ROTATION    = 2'd1;
	localparam logic [1:0] KIND_BUTTON      = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_TRANS_DZ   = 2'd0;
	localparam logic [1:0] CFG_ROT_DZ     = 2'd1;
	localparam logic [1:0] CFG_BUTTONS_EN = 2'd2;

	// Report lengths and ids that carry data.
	localparam logic [3:0] LEN_SHORT  = 4'd3;
	localparam logic [3:0] LEN_SINGLE = 4'd7;
	localparam logic [3:0] LEN_DOUBLE = 4'd13;
	localparam logic [7:0] ID_MOTION   = 8'd1;
	localparam logic [7:0] ID_ROTATION = 8'd2;
	localparam logic [7:0] ID_BUTTONS  = 8'd3;

	localparam logic [6:0] DZ_RESET = 7'd35;

	typedef struct packed {
		logic [3:0]  report_length;
		logic [7:0]  report_id;
		logic [15:0] word_a;
		logic [15:0] word_b;
		logic [15:0] word_c;
		logic [15:0] word_d;
		logic [15:0] word_e;
		logic [15:0] word_f;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic [4:0]         button_index;
		logic               last;
	} result_t;

	// What the decoder makes of one report: up to two results, in order.
	typedef struct packed {
		logic    first_valid;
		logic    second_valid;
		result_t first;
		result_t second;
	} decoded_t;

endpackage

// ===== rtl/core/six_axis_hid_report_decoder.sv =====
// Channel        Handshake                Payload
// report in      start, busy              report_length, report_id, word_a .. word_f
// result out     result_valid             kind, axis_x, axis_y, axis_z, button_index, last
// configuration  cfg_write                cfg_index, cfg_data
//
// A report enters the input register at an edge where start is high and busy low; its
// first result then passes to the output register and is on the result ports for one cycle.
// A report with both a translation and a rotation sends the rotation in the cycle after the
// first result; reports with at most one result can follow back to back.
// busy is raised only while that second result waits and a further report already sits in
// the input register. The receiver cannot stall. Reset clears the valid flags and presets the cfg registers.
`include "six_axis_hid_report_decoder_macros.svh"
module six_axis_hid_report_decoder import shdr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         report_length,
	input  logic [7:0]         report_id,
	input  logic [15:0]        word_a,
	input  logic [15:0]        word_b,
	input  logic [15:0]        word_c,
	input  logic [15:0]        word_d,
	input  logic [15:0]        word_e,
	input  logic [15:0]        word_f,
	output logic               result_valid,
	output logic [1:0]         kind,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic [4:0]         button_index,
	output logic               last,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	// Configuration registers.
	logic [6:0] trans_dz_q;
	logic [6:0] rot_dz_q;
	logic       buttons_en_q;

	// Input register holding one report.
	logic       valid_s1;
	item_t      item_s1;

	// Second result waiting its turn, and the output register.
	logic       pend_valid_q;
	result_t    pend_q;
	logic       out_valid_q;
	result_t    out_q;

	decoded_t   dec;
	logic       accept;
	logic       advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trans_dz_q   <= DZ_RESET;
			rot_dz_q     <= DZ_RESET;
			buttons_en_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_TRANS_DZ:   trans_dz_q <= cfg_data;
				CFG_ROT_DZ:     rot_dz_q <= cfg_data;
				CFG_BUTTONS_EN: buttons_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The input register can only move on when no second result is waiting, since the
	// pending result has the output register to itself for that cycle.
	assign advance = valid_s1 && !pend_valid_q;
	assign busy = valid_s1 && pend_valid_q;
	assign accept = start && !busy;

	shdr_decode u_decode (
		.item       (item_s1),
		.trans_dz   (trans_dz_q),
		.rot_dz     (rot_dz_q),
		.buttons_en (buttons_en_q),
		.dec        (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			pend_valid_q <= advance && dec.second_valid;
			out_valid_q <= pend_valid_q || (advance && dec.first_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{report_length: report_length, report_id: report_id,
				word_a: word_a, word_b: word_b, word_c: word_c,
				word_d: word_d, word_e: word_e, word_f: word_f};
		end
		if (advance) begin
			pend_q <= dec.second;
		end
		out_q <= pend_valid_q ? pend_q : dec.first;
	end

	assign result_valid = out_valid_q;
	assign kind = out_q.kind;
	assign axis_x = out_q.axis_x;
	assign axis_y = out_q.axis_y;
	assign axis_z = out_q.axis_z;
	assign button_index = out_q.button_index;
	assign last = out_q.last;

	// A second result is only ever queued behind a first one going out in the same cycle.
	`SHDR_ASSERT_SAME(a_pend_behind_first, pend_valid_q, result_valid && !last, "orphan second result")
	// A result that is not the last of its report is followed at once by another.
	`SHDR_ASSERT_NEXT(a_second_follows, result_valid && !last, result_valid, "no second result")
	// The block only refuses a report while a second result is waiting.
	`SHDR_ASSERT_SAME(a_busy_cause, busy, pend_valid_q && valid_s1, "busy without a pending result")
	// A transfer in always fills the input register.
	`SHDR_ASSERT_NEXT(a_accept_fills, start && !busy, valid_s1, "accepted report was lost")

endmodule

// ===== rtl/core/shdr_decode.sv =====
module shdr_decode import shdr_pkg::*; (
	input  item_t      item,
	input  logic [6:0] trans_dz,
	input  logic [6:0] rot_dz,
	input  logic       buttons_en,
	output decoded_t   dec
);

	// Deadzone, then optional negation with saturation of the most negative value.
	function automatic logic signed [15:0] axis_fn(input logic [15:0] raw,
			input logic [6:0] dz, input logic neg);
		logic [16:0]        mag;
		logic signed [15:0] v;
		mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
		v = (mag > {10'd0, dz}) ? $signed(raw) : 16'sd0;
		if (neg) begin
			v = (v == 16'sh8000) ? 16'sh7fff : -v;
		end
		return v;
	endfunction

	logic               len_vec;
	logic               is_button;
	logic               want_trans;
	logic               want_rot;
	logic [15:0]        rot_a;
	logic [15:0]        rot_b;
	logic [15:0]        rot_c;
	logic signed [15:0] tx, ty, tz;
	logic signed [15:0] rx, ry, rz;
	logic [31:0]        btn_bits;
	logic [4:0]         btn_idx;
	logic               v_trans, v_rot, v_btn;
	result_t            res_trans, res_rot, res_btn;

	assign len_vec = (item.report_length == LEN_SINGLE) || (item.report_length == LEN_DOUBLE);
	assign is_button = (item.report_id == ID_BUTTONS) && (len_vec
		|| (item.report_length == LEN_SHORT));
	assign want_trans = len_vec && (item.report_id == ID_MOTION);
	assign want_rot = ((item.report_length == LEN_SINGLE) && (item.report_id == ID_ROTATION))
		|| ((item.report_length == LEN_DOUBLE) && (item.report_id == ID_MOTION));

	// A long report carries its rotation in the second half.
	assign rot_a = (item.report_length == LEN_DOUBLE) ? item.word_d : item.word_a;
	assign rot_b = (item.report_length == LEN_DOUBLE) ? item.word_e : item.word_b;
	assign rot_c = (item.report_length == LEN_DOUBLE) ? item.word_f : item.word_c;

	assign tx = axis_fn(item.word_a, trans_dz, 1'b1);
	assign ty = axis_fn(item.word_b, trans_dz, 1'b0);
	assign tz = axis_fn(item.word_c, trans_dz, 1'b0);
	assign rx = axis_fn(rot_a, rot_dz, 1'b1);
	assign ry = axis_fn(rot_b, rot_dz, 1'b0);
	assign rz = axis_fn(rot_c, rot_dz, 1'b1);

	// In the short report only bytes 1 and 2 were received.
	assign btn_bits = (item.report_length == LEN_SHORT) ? {16'd0, item.word_a}
		: {item.word_b, item.word_a};

	always_comb begin
		btn_idx = 5'd0;
		for (int i = 31; i >= 0; i--) begin
			if (btn_bits[i]) begin
				btn_idx = 5'(i);
			end
		end
	end

	assign v_trans = want_trans && ((tx != 16'sd0) || (ty != 16'sd0) || (tz != 16'sd0));
	assign v_rot = want_rot && ((rx != 16'sd0) || (ry != 16'sd0) || (rz != 16'sd0));
	assign v_btn = is_button && buttons_en && (btn_bits != 32'd0);

	always_comb begin
		res_trans = '{kind: KIND_TRANSLATION, axis_x: tx, axis_y: ty, axis_z: tz,
			button_index: 5'd0, last: 1'b1};
		res_rot = '{kind: KIND_ROTATION, axis_x: rx, axis_y: ry, axis_z: rz,
			button_index: 5'd0, last: 1'b1};
		res_btn = '{kind: KIND_BUTTON, axis_x: 16'sd0, axis_y: 16'sd0, axis_z: 16'sd0,
			button_index: btn_idx, last: 1'b1};
	end

	always_comb begin
		dec.first_valid = v_trans || v_rot || v_btn;
		dec.second_valid = v_trans && v_rot;
		dec.second = res_rot;
		priority if (v_trans) begin
			dec.first = res_trans;
			dec.first.last = !v_rot;
		end else if (v_rot) begin
			dec.first = res_rot;
		end else begin
			dec.first = res_btn;
		end
	end

endmodule
